@@ hdl/dcs_pkg.sv @@
package dcs_pkg;

  localparam int unsigned MAX_PRECISION_DEF = 10;
  localparam int unsigned MIN_PRECISION     = 4;
  localparam int unsigned PRECISION_RESET   = 10;
  localparam int unsigned SUM_W             = 43;
  localparam int unsigned ZCNT_W            = 11;
  localparam int unsigned RANK_W            = 5;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    MODE_ITEM    = 2'd0,
    MODE_MERGE   = 2'd1,
    MODE_SUMMARY = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  // finished item hash handed from the hash stage to the update pipeline
  typedef struct packed {
    logic        valid;
    logic [31:0] hash;
  } fin_t;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

  // leading-zero count by binary search; 32 for an all-zero word
  function automatic logic [5:0] clz32(input logic [31:0] w);
    logic [31:0] v;
    logic [5:0]  n;
    v = w;
    n = 6'd0;
    if (v == 32'd0) begin
      n = 6'd32;
    end else begin
      if (v[31:16] == 16'd0) begin
        n = n + 6'd16;
        v = v << 16;
      end
      if (v[31:24] == 8'd0) begin
        n = n + 6'd8;
        v = v << 8;
      end
      if (v[31:28] == 4'd0) begin
        n = n + 6'd4;
        v = v << 4;
      end
      if (v[31:30] == 2'd0) begin
        n = n + 6'd2;
        v = v << 2;
      end
      if (v[31] == 1'b0) begin
        n = n + 6'd1;
      end
    end
    return n;
  endfunction

endpackage

@@ hdl/distinct_count_sketch.sv @@
// HyperLogLog distinct-count sketch over a 32-bit FNV-1a hash.
// Input channel (in_valid / in_stall): one transaction per item byte (mode item),
// merge entry, summarize request or clear request. Item bytes and merge entries
// are taken one per cycle while in_stall is low; the register update follows the
// last byte through the hash register and a read-modify-write pipeline on the
// register store, with forwarding of the previous write so back-to-back updates
// of one entry stay exact. Summarize waits for the update pipeline to drain,
// then reads the 2^p used registers one per cycle through the store's single
// read port. Clear drains the pipeline the same way and then writes
// 2^MAX_PRECISION entries, one per cycle.
// Output channel (out_valid / out_stall): one transaction per summarize,
// harmonic_sum in unsigned 11.32 and zero_count. The result sits in an output
// register; new items are taken while it waits. A second summary holds in its
// final state until the receiver takes the first one.
// Reset starts a clearing pass over all 2^MAX_PRECISION entries (1024 by default)
// with in_stall high. The precision port (cfg_valid / cfg_ready) is always ready;
// the user must write it only while the block is idle; the block does not enforce this.
module distinct_count_sketch
  import dcs_pkg::*;
#(
  parameter int unsigned MAX_PRECISION = MAX_PRECISION_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         precision,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic [9:0]         entry_index,
  input  logic [4:0]         entry_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SUM_W-1:0]   harmonic_sum,
  output logic [ZCNT_W-1:0]  zero_count
);

  localparam int unsigned AW = MAX_PRECISION;
  localparam int unsigned PW = ($clog2(MAX_PRECISION + 1) > 4) ?
                               $clog2(MAX_PRECISION + 1) : 4;
  localparam int unsigned PREC_INIT = (PRECISION_RESET > MAX_PRECISION) ?
                                      MAX_PRECISION : PRECISION_RESET;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DRAIN = 6'b000010,
    ST_CLEAR = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_LAST  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [PW-1:0]     prec;
  logic [PW-1:0]     cfg_ext;
  logic              in_accept;
  mode_t             in_mode;
  logic [AW-1:0]     cnt, cnt_next;
  logic [AW:0]       last_used;
  logic              is_sum;

  fin_t              fin;
  logic [AW-1:0]     rank_idx;
  logic [RANK_W-1:0] rank_rho;

  logic              m1_valid;
  logic [AW-1:0]     m1_idx;
  logic [RANK_W-1:0] m1_val;

  logic              s1_valid;
  logic [AW-1:0]     s1_idx;
  logic [RANK_W-1:0] s1_val;

  logic              s2_valid;
  logic [AW-1:0]     s2_idx;
  logic [RANK_W-1:0] s2_val;
  logic [RANK_W-1:0] s2_old;
  logic              s2_write;

  logic              wr_valid;
  logic [AW-1:0]     wr_idx;
  logic [RANK_W-1:0] wr_val;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [RANK_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [RANK_W-1:0] mem_rdata;

  logic              acc_en;
  logic [SUM_W-1:0]  acc_sum;
  logic [ZCNT_W-1:0] acc_zero;
  logic [SUM_W-1:0]  term;
  logic              out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_mode   = mode_t'(mode);

  // precision register, clamped to the supported range
  always_comb begin
    cfg_ext = PW'(precision);
    if (cfg_ext < PW'(MIN_PRECISION)) begin
      cfg_ext = PW'(MIN_PRECISION);
    end else if (cfg_ext > PW'(MAX_PRECISION)) begin
      cfg_ext = PW'(MAX_PRECISION);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prec <= PW'(PREC_INIT);
    end else if (cfg_valid && cfg_ready) begin
      prec <= cfg_ext;
    end
  end

  dcs_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (in_accept && (in_mode == MODE_ITEM)),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .fin       (fin)
  );

  dcs_rank #(
    .AW (AW),
    .PW (PW)
  ) u_rank (
    .hash (fin.hash),
    .prec (prec),
    .idx  (rank_idx),
    .rho  (rank_rho)
  );

  // merge entries enter at the same stage as finished hashes
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= in_accept && (in_mode == MODE_MERGE) && ((entry_index >> prec) == 10'd0);
    end
  end

  always_ff @(posedge clk) begin
    m1_idx <= AW'(entry_index);
    m1_val <= entry_value;
  end

  assign s1_valid = fin.valid || m1_valid;
  assign s1_idx   = fin.valid ? rank_idx : m1_idx;
  assign s1_val   = fin.valid ? rank_rho : m1_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_idx <= s1_idx;
    s2_val <= s1_val;
  end

  // the read for this entry was issued while the previous write landed
  assign s2_old   = (wr_valid && (wr_idx == s2_idx)) ? wr_val : mem_rdata;
  assign s2_write = s2_valid && (s2_val > s2_old);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else begin
      wr_valid <= s2_write;
    end
  end

  always_ff @(posedge clk) begin
    wr_idx <= s2_idx;
    wr_val <= s2_val;
  end

  always_comb begin
    mem_we    = s2_write;
    mem_waddr = s2_idx;
    mem_wdata = s2_val;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt;
      mem_wdata = '0;
    end
    mem_raddr = (state == ST_SUM) ? cnt : s1_idx;
  end

  dcs_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign last_used = ((AW + 1)'(1) << prec) - (AW + 1)'(1);
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_accept && ((in_mode == MODE_SUMMARY) || (in_mode == MODE_CLEAR))) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!fin.valid && !m1_valid && !s2_valid) begin
          cnt_next   = '0;
          state_next = is_sum ? ST_SUM : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cnt_next = cnt + AW'(1);
        if (&cnt) begin
          state_next = ST_IDLE;
        end
      end
      ST_SUM: begin
        cnt_next = cnt + AW'(1);
        if ((AW + 1)'(cnt) == last_used) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      cnt    <= '0;
      acc_en <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      acc_en <= (state == ST_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_accept) begin
      is_sum <= (in_mode == MODE_SUMMARY);
    end
  end

  assign term = SUM_W'(1) << (6'd32 - 6'(mem_rdata));

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) begin
      acc_sum  <= '0;
      acc_zero <= '0;
    end else if (acc_en) begin
      acc_sum  <= acc_sum + term;
      acc_zero <= acc_zero + ZCNT_W'(mem_rdata == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      harmonic_sum <= acc_sum;
      zero_count   <= acc_zero;
    end
  end

endmodule

@@ hdl/dcs_mem.sv @@
module dcs_mem
  import dcs_pkg::*;
#(
  parameter int unsigned AW = MAX_PRECISION_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [RANK_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [RANK_W-1:0] rdata
);

  logic [RANK_W-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/dcs_hash.sv @@
module dcs_hash
  import dcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_en,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output fin_t       fin
);

  logic [31:0] running;
  logic [31:0] stepped;

  assign stepped = fnv_step(running, data_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= FNV_BASIS;
      fin.valid <= 1'b0;
    end else begin
      fin.valid <= byte_en && last_byte;
      if (byte_en) begin
        // restart from the offset basis once the item ends
        running <= last_byte ? FNV_BASIS : stepped;
      end
    end
    if (byte_en) begin
      fin.hash <= stepped;
    end
  end

endmodule

@@ hdl/dcs_rank.sv @@
module dcs_rank
  import dcs_pkg::*;
#(
  parameter int unsigned AW = MAX_PRECISION_DEF,
  parameter int unsigned PW = 4
) (
  input  logic [31:0]       hash,
  input  logic [PW-1:0]     prec,
  output logic [AW-1:0]     idx,
  output logic [RANK_W-1:0] rho
);

  logic [5:0]  shr;
  logic [31:0] upper;
  logic [31:0] rest;
  logic [5:0]  lz;

  always_comb begin
    shr   = 6'd32 - 6'(prec);
    upper = hash >> shr;
    idx   = AW'(upper);
    rest  = hash << prec;
    lz    = clz32(rest);
    if (rest == 32'd0) begin
      rho = RANK_W'(6'd33 - 6'(prec));
    end else begin
      rho = RANK_W'(lz + 6'd1);
    end
  end

endmodule

@@ hdl/dcs_checker.sv @@
module dcs_checker
  import dcs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        mode,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SUM_W-1:0]  harmonic_sum
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(harmonic_sum))
    else $error("stalled result changed");

  // reset starts the clearing pass
  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open right after reset");

  // a summarize request closes the input while the store is walked
  a_sum_walk: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == MODE_SUMMARY) |=> in_stall)
    else $error("input open after summarize request");

  // every term 2^(32-r) is even
  a_sum_even: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !harmonic_sum[0])
    else $error("odd harmonic sum");

endmodule

bind distinct_count_sketch dcs_checker u_dcs_checker (.*);
